@@ src/annexb_pkg.sv @@
// Shared types and constants for the Annex B NAL unit splitter.
// Used by annexb_parse, annexb_outq and the top level annexb_nal_unit_splitter.
`timescale 1ns / 1ps

package annexb_pkg;

	localparam int BURST       = 4;
	localparam int BURST_W     = 3;
	localparam int QDEPTH      = 16;
	localparam int QIDX_W      = 4;
	localparam int QCNT_W      = 5;
	localparam int STALL_LEVEL = QDEPTH - 2 * BURST;
	localparam int HIST_DEPTH  = 3;
	localparam int LEN_W       = 18;
	localparam logic [LEN_W-1:0] LEN_MAX = 18'h3ffff;

	localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
	localparam logic [7:0] HDR_REF_IDC_MASK   = 8'h60;
	localparam logic [7:0] HDR_TYPE_MASK      = 8'h1f;

	typedef struct packed {
		logic [7:0]       data;
		logic             first;
		logic             last;
		logic [7:0]       header;
		logic             long_pfx;
		logic [LEN_W-1:0] length;
	} item_t;

	typedef struct packed {
		logic [BURST_W-1:0]  count;
		item_t [BURST-1:0]   items;
	} burst_t;

	typedef struct packed {
		logic              valid;
		logic [QCNT_W-1:0] level;
	} q_status_t;

endpackage

@@ src/annexb_parse.sv @@
// Input register and start code parser: holds the unit state and turns one
// stream byte into a burst of zero to four result transactions. Uses annexb_pkg.
`timescale 1ns / 1ps

module annexb_parse #(
	parameter int MAX_UNIT_BYTES = 262143
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          in_byte,
	input  logic                end_of_stream,
	output annexb_pkg::burst_t  push
);

	localparam int CNT_W = $clog2(MAX_UNIT_BYTES + 1);
	localparam int SUM_W = CNT_W + annexb_pkg::BURST_W;
	localparam int EXT_W = (CNT_W > annexb_pkg::LEN_W) ? CNT_W : annexb_pkg::LEN_W;
	localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_UNIT_BYTES);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eos_s1;

	logic [7:0]             hist_q [annexb_pkg::HIST_DEPTH];
	logic [1:0]             fill_q;
	logic                   inside_q;
	logic                   expect_q;
	logic [7:0]             header_q;
	logic                   long_q;
	logic [CNT_W-1:0]       count_q;

	logic [7:0]             hist_n [annexb_pkg::HIST_DEPTH];
	logic [1:0]             fill_n;
	logic                   inside_n;
	logic                   start;
	logic                   start_long;
	logic                   cand;
	logic [1:0]             zeros;
	logic [1:0]             a_n;
	logic                   a_last;
	logic [1:0]             b_n;
	logic [annexb_pkg::BURST_W-1:0] n_tot;
	annexb_pkg::item_t [annexb_pkg::BURST-1:0] items;
	logic [7:0]             hdr_cur;

	function automatic logic [7:0] pick(input logic [7:0] h [annexb_pkg::HIST_DEPTH],
			input logic [1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		for (int k = 0; k < annexb_pkg::HIST_DEPTH; k++) begin
			if (idx == 2'(k)) begin
				r = h[k];
			end
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
			input logic [annexb_pkg::BURST_W-1:0] k);
		logic [SUM_W-1:0] s;
		s = SUM_W'(c) + SUM_W'(k);
		if (s > MAX_SUM) begin
			s = MAX_SUM;
		end
		return s[CNT_W-1:0];
	endfunction

	function automatic logic [annexb_pkg::LEN_W-1:0] clip_len(input logic [CNT_W-1:0] c);
		logic [EXT_W-1:0] e;
		e = EXT_W'(c);
		if (e > EXT_W'(annexb_pkg::LEN_MAX)) begin
			e = EXT_W'(annexb_pkg::LEN_MAX);
		end
		return e[annexb_pkg::LEN_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_stream;
		end
	end

	always_comb begin
		cand       = (fill_q != 2'd0) && (hist_q[0] != 8'h00);
		zeros      = fill_q - 2'(cand);
		hist_n     = hist_q;
		fill_n     = fill_q;
		inside_n   = inside_q;
		start      = 1'b0;
		start_long = 1'b0;
		a_n        = 2'd0;
		a_last     = 1'b0;
		if (inside_q) begin
			if (byte_s1 == 8'h00 && zeros < 2'd2) begin
				for (int k = 0; k < annexb_pkg::HIST_DEPTH; k++) begin
					if (fill_q == 2'(k)) begin
						hist_n[k] = 8'h00;
					end
				end
				fill_n = fill_q + 2'd1;
			end else if (byte_s1 == 8'h00) begin
				a_n      = 2'(cand);
				a_last   = 1'b1;
				inside_n = 1'b0;
				fill_n   = 2'd3;
			end else if (byte_s1 == 8'h01 && zeros == 2'd2) begin
				a_n    = 2'(cand);
				a_last = 1'b1;
				start  = 1'b1;
			end else begin
				a_n       = fill_q;
				hist_n[0] = byte_s1;
				fill_n    = 2'd1;
			end
		end else begin
			if (byte_s1 == 8'h00) begin
				if (fill_q != 2'd3) begin
					fill_n = fill_q + 2'd1;
				end
			end else if (byte_s1 == 8'h01 && fill_q >= 2'd2) begin
				start      = 1'b1;
				start_long = (fill_q == 2'd3);
			end else begin
				fill_n = 2'd0;
			end
		end
		if (start) begin
			inside_n = 1'b1;
			fill_n   = 2'd0;
		end
		b_n   = (eos_s1 && inside_n) ? fill_n : 2'd0;
		n_tot = annexb_pkg::BURST_W'(a_n) + annexb_pkg::BURST_W'(b_n);

		for (int i = 0; i < annexb_pkg::BURST; i++) begin
			if (annexb_pkg::BURST_W'(i) < annexb_pkg::BURST_W'(a_n)) begin
				items[i].data = pick(hist_q, 2'(i));
				items[i].last = a_last;
			end else begin
				items[i].data = pick(hist_n, 2'(annexb_pkg::BURST_W'(i) -
					annexb_pkg::BURST_W'(a_n)));
				items[i].last = (annexb_pkg::BURST_W'(i) + 3'd1 == n_tot);
			end
		end
		hdr_cur = expect_q ? items[0].data : header_q;
		for (int i = 0; i < annexb_pkg::BURST; i++) begin
			items[i].first    = expect_q && (i == 0);
			items[i].header   = hdr_cur;
			items[i].long_pfx = long_q;
			items[i].length   = items[i].last ?
				clip_len(sat_add(count_q, annexb_pkg::BURST_W'(i + 1))) :
				'0;
		end
		push.items = items;
		push.count = valid_s1 ? n_tot : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			inside_q <= 1'b0;
			expect_q <= 1'b0;
			header_q <= 8'h00;
			long_q   <= 1'b0;
			count_q  <= '0;
		end else if (valid_s1) begin
			fill_q   <= fill_n;
			inside_q <= inside_n;
			if (n_tot != '0) begin
				count_q <= sat_add(count_q, n_tot);
				if (expect_q) begin
					header_q <= items[0].data;
					expect_q <= 1'b0;
				end
			end
			if (start) begin
				expect_q <= 1'b1;
				long_q   <= start_long;
				header_q <= 8'h00;
				count_q  <= '0;
			end
			if (eos_s1) begin
				fill_q   <= 2'd0;
				inside_q <= 1'b0;
				expect_q <= 1'b0;
				header_q <= 8'h00;
				long_q   <= 1'b0;
				count_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hist_q <= hist_n;
		end
	end

endmodule

@@ src/annexb_outq.sv @@
// Result queue: takes a burst of up to four transactions per cycle and hands
// them out one per cycle on the output side while pop is high. Uses annexb_pkg.
`timescale 1ns / 1ps

module annexb_outq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  annexb_pkg::burst_t      push,
	input  logic                    pop,
	output annexb_pkg::item_t       head,
	output annexb_pkg::q_status_t   status
);

	annexb_pkg::item_t              q_q [annexb_pkg::QDEPTH];
	logic [annexb_pkg::QIDX_W-1:0]  wptr_q;
	logic [annexb_pkg::QIDX_W-1:0]  rptr_q;
	logic [annexb_pkg::QCNT_W-1:0]  level_q;
	logic                           do_pop;

	assign do_pop        = pop && (level_q != '0);
	assign head          = q_q[rptr_q];
	assign status.valid  = (level_q != '0);
	assign status.level  = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			wptr_q  <= wptr_q + annexb_pkg::QIDX_W'(push.count);
			rptr_q  <= rptr_q + annexb_pkg::QIDX_W'(do_pop);
			level_q <= level_q + annexb_pkg::QCNT_W'(push.count) -
				annexb_pkg::QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < annexb_pkg::BURST; i++) begin
			if (annexb_pkg::BURST_W'(i) < push.count) begin
				q_q[wptr_q + annexb_pkg::QIDX_W'(i)] <= push.items[i];
			end
		end
	end

endmodule

@@ src/annexb_nal_unit_splitter.sv @@
// Top level of the Annex B NAL unit splitter: handshake control and header
// field decode. Instantiates annexb_parse and annexb_outq; uses annexb_pkg.
`timescale 1ns / 1ps

// Takes one stream byte per cycle while in_stall is low and returns the NAL unit
// bytes with start codes removed, each tagged with first/last marks, the header
// fields and, on the last byte, the saturating unit length. A byte is parsed in
// the cycle after it is accepted and, with an idle output, its results reach the
// output port in the cycle after that. One byte can release up to four results
// at once (held bytes plus a flush at end of stream); these go into a 16-entry
// result queue, and in_stall rises while that queue holds more than eight
// results. With the output side taking every cycle the block sustains one input
// byte per cycle. Bytes ahead of the first start code are dropped.

module annexb_nal_unit_splitter #(
	parameter int MAX_UNIT_BYTES = 262143
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  nal_byte,
	output logic        first_of_unit,
	output logic        last_of_unit,
	output logic [4:0]  unit_type,
	output logic [1:0]  ref_idc,
	output logic        forbidden,
	output logic        long_prefix,
	output logic [17:0] unit_length
);

	annexb_pkg::burst_t     push;
	annexb_pkg::item_t      head;
	annexb_pkg::q_status_t  status;
	logic                   take;
	logic [7:0]             hdr;

	assign in_stall = (status.level > annexb_pkg::QCNT_W'(annexb_pkg::STALL_LEVEL));
	assign take     = in_valid && !in_stall;

	annexb_parse #(
		.MAX_UNIT_BYTES (MAX_UNIT_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.push          (push)
	);

	annexb_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (!out_stall),
		.head   (head),
		.status (status)
	);

	assign hdr           = head.header;
	assign out_valid     = status.valid;
	assign nal_byte      = head.data;
	assign first_of_unit = head.first;
	assign last_of_unit  = head.last;
	assign unit_type     = 5'(hdr & annexb_pkg::HDR_TYPE_MASK);
	assign ref_idc       = 2'((hdr & annexb_pkg::HDR_REF_IDC_MASK) >> 5);
	assign forbidden     = 1'((hdr & annexb_pkg::HDR_FORBIDDEN_MASK) >> 7);
	assign long_prefix   = head.long_pfx;
	assign unit_length   = head.length;

endmodule
